// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the round-robin quantum queue RTL.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define RRQQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RRQQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/rrqq_pkg.sv -----
// Package for the round-robin quantum queue: request and result types,
// command and status codes, sequencer states. No dependencies.
`default_nettype none
package rrqq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam logic [15:0] QUANTUM_RST = 16'd5;

  localparam logic [1:0] CMD_JOIN  = 2'd0;
  localparam logic [1:0] CMD_SERVE = 2'd1;
  localparam logic [1:0] CMD_SWAP  = 2'd2;
  localparam logic [1:0] CMD_QUIT  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] id;
    logic [15:0] other_id;
    logic [15:0] need_time;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_id;
    logic [15:0] granted_time;
    logic        requeued;
    logic [15:0] remaining_time;
    logic [4:0]  queue_count;
  } out_res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] time_left;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SERVE,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/rrqq_ram.sv -----
// Entry store of the queue: one write port, one read port with registered data.
// Depends on rrqq_pkg for the entry type.
`default_nettype none
module rrqq_ram #(
  parameter int DEPTH = rrqq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                   clk,
  input  wire                   we,
  input  wire  [AW-1:0]         waddr,
  input  wire rrqq_pkg::entry_t wdata,
  input  wire  [AW-1:0]         raddr,
  output rrqq_pkg::entry_t      rdata
);
  import rrqq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hdl/round_robin_quantum_queue_top.sv -----
// Round-robin quantum queue: a sequencer over a circular entry store.
// Join writes at the tail, serve takes the head entry, and swap and quit scan the
// queued entries through the single store read port; quit then shifts later ones.
// One request at a time; a new request is taken while the last result waits.
// Reset is synchronous: queue empty, quantum 5, store contents left undefined.
`default_nettype none
module round_robin_quantum_queue_top #(
  parameter int CAPACITY = rrqq_pkg::CAPACITY_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire rrqq_pkg::in_req_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output rrqq_pkg::out_res_t  out_data,
  input  wire                 cfg_we,
  input  wire  [15:0]         cfg_wdata
);
  import rrqq_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t   state_r, state_nxt;
  in_req_t  req_r;
  out_res_t res_r, res_nxt;
  out_res_t res_out;
  out_res_t out_data_r;
  logic     out_valid_r;
  logic [15:0]   quantum_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          fa_r, fa_nxt, fb_r, fb_nxt;
  logic [AW-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  entry_t        da_r, da_nxt, db_r, db_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail_addr;
  logic [CW-1:0] last_idx;
  logic [AW-1:0] scan_inc;
  logic          hit_a, hit_b, scan_done, both_found;
  logic [31:0]   count_ext;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
  endfunction

  rrqq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign tail_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign tail_addr = (tail_sum >= (CW+1)'(CAPACITY)) ?
                     AW'(tail_sum - (CW+1)'(CAPACITY)) : AW'(tail_sum);
  assign last_idx  = count_r - CW'(1);
  assign scan_inc  = wrap_inc(scan_ptr_r);
  assign count_ext = 32'(count_r);

  assign hit_a      = !fa_r && (rdata.id == req_r.id);
  assign hit_b      = !fb_r && (rdata.id == req_r.other_id) && (req_r.cmd == CMD_SWAP);
  assign both_found = (fa_r || hit_a) && (fb_r || hit_b);
  assign scan_done  = (idx_r == last_idx) ||
                      ((req_r.cmd == CMD_SWAP) ? both_found : (fa_r || hit_a));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    res_out             = res_r;
    res_out.queue_count = count_ext[4:0];
  end

  always_comb begin
    state_nxt    = state_r;
    res_nxt      = res_r;
    count_nxt    = count_r;
    head_nxt     = head_r;
    scan_ptr_nxt = scan_ptr_r;
    idx_nxt      = idx_r;
    fa_nxt       = fa_r;
    fb_nxt       = fb_r;
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    ia_nxt       = ia_r;
    da_nxt       = da_r;
    db_nxt       = db_r;
    we           = 1'b0;
    waddr        = tail_addr;
    wdata        = '{id: req_r.id, time_left: req_r.need_time};
    raddr        = head_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = ST_OK;
        scan_ptr_nxt   = head_r;
        idx_nxt        = '0;
        fa_nxt         = 1'b0;
        fb_nxt         = 1'b0;
        if (req_r.cmd == CMD_JOIN) begin
          if (count_r == CW'(CAPACITY)) begin
            res_nxt.status = ST_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_DONE;
        end else if (count_r == '0) begin
          res_nxt.status = ST_EMPTY;
          state_nxt      = S_DONE;
        end else if (req_r.cmd == CMD_SERVE) begin
          state_nxt = S_SERVE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SERVE: begin
        res_nxt.served_id = rdata.id;
        head_nxt          = wrap_inc(head_r);
        if (rdata.time_left <= quantum_r || count_r == CW'(1)) begin
          res_nxt.granted_time = rdata.time_left;
          count_nxt            = count_r - CW'(1);
        end else begin
          res_nxt.granted_time   = quantum_r;
          res_nxt.requeued       = 1'b1;
          res_nxt.remaining_time = rdata.time_left - quantum_r;
          we    = 1'b1;
          wdata = '{id: rdata.id, time_left: rdata.time_left - quantum_r};
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        raddr = scan_inc;
        if (hit_a) begin
          fa_nxt = 1'b1;
          pa_nxt = scan_ptr_r;
          ia_nxt = idx_r;
          da_nxt = rdata;
        end
        if (hit_b) begin
          fb_nxt = 1'b1;
          pb_nxt = scan_ptr_r;
          db_nxt = rdata;
        end
        if (!scan_done) begin
          scan_ptr_nxt = scan_inc;
          idx_nxt      = idx_r + CW'(1);
        end else if (req_r.cmd == CMD_SWAP) begin
          if (both_found) begin
            state_nxt = S_SWAP_A;
          end else begin
            res_nxt.status = ST_NOTFOUND;
            state_nxt      = S_DONE;
          end
        end else if (fa_r || hit_a) begin
          scan_ptr_nxt = hit_a ? scan_ptr_r : pa_r;
          idx_nxt      = hit_a ? idx_r : ia_r;
          if ((hit_a ? idx_r : ia_r) == last_idx) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end
      end
      S_SWAP_A: begin
        we        = 1'b1;
        waddr     = pa_r;
        wdata     = db_r;
        state_nxt = S_SWAP_B;
      end
      S_SWAP_B: begin
        we        = 1'b1;
        waddr     = pb_r;
        wdata     = da_r;
        state_nxt = S_DONE;
      end
      S_SHIFT_RD: begin
        raddr     = scan_inc;
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we           = 1'b1;
        waddr        = scan_ptr_r;
        wdata        = rdata;
        scan_ptr_nxt = scan_inc;
        idx_nxt      = idx_r + CW'(1);
        if (idx_r + CW'(1) == last_idx) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      quantum_r   <= QUANTUM_RST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_data_r <= res_out;
    end
    res_r      <= res_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    idx_r      <= idx_nxt;
    fa_r       <= fa_nxt;
    fb_r       <= fb_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    ia_r       <= ia_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
  end

  `RRQQ_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "queue count above capacity")
  `RRQQ_ASSERT(a_head_bound, head_r <= AW'(CAPACITY - 1), "head pointer out of range")
  `RRQQ_ASSERT(a_accept_exec, (in_valid && in_ready) |=> (state_r == S_EXEC), "request not executed")
  `RRQQ_ASSERT(a_idle_count, (state_r == S_IDLE) |=> (count_r == $past(count_r)), "count moved while idle")
  `RRQQ_ASSERT_ALWAYS(a_reset, !rst_n |=> (state_r == S_IDLE && count_r == '0 && !out_valid_r), "reset state wrong")

endmodule
`default_nettype wire
